// ===== rtl/ilt_pkg.sv =====
`timescale 1ns / 1ps

package ilt_pkg;

	// length bound for a name or pair, counting the key/value separator; held counts stay below it
	localparam int MAX_LEN = 4096;
	localparam int LEN_W   = $clog2(MAX_LEN) + 1;

	// result queue
	localparam int FIFO_DEPTH = 4;
	localparam int PTR_W      = $clog2(FIFO_DEPTH);
	localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

	localparam logic [7:0] CH_LBRACKET = 8'h5B;
	localparam logic [7:0] CH_RBRACKET = 8'h5D;
	localparam logic [7:0] CH_SEMI     = 8'h3B;
	localparam logic [7:0] CH_EQUALS   = 8'h3D;
	localparam logic [7:0] CH_NEWLINE  = 8'h0A;
	localparam logic [7:0] CH_TAB      = 8'h09;
	localparam logic [7:0] CH_SPACE    = 8'h20;

	typedef enum logic [3:0] {
		PH_LINE     = 4'd0,
		PH_SECT     = 4'd1,
		PH_SECT_END = 4'd2,
		PH_COMMENT  = 4'd3,
		PH_KEY      = 4'd4,
		PH_KEY_GAP  = 4'd5,
		PH_VALUE    = 4'd6,
		PH_VALUE_NL = 4'd7,
		PH_DONE     = 4'd8,
		PH_ERROR    = 4'd9
	} phase_t;

	typedef enum logic [2:0] {
		EV_NONE      = 3'd0,
		EV_SECT_CHAR = 3'd1,
		EV_SECT_END  = 3'd2,
		EV_KEY_CHAR  = 3'd3,
		EV_KEY_END   = 3'd4,
		EV_VAL_CHAR  = 3'd5,
		EV_PAIR_END  = 3'd6,
		EV_FINISHED  = 3'd7
	} event_t;

	typedef enum logic [1:0] {
		ST_OK     = 2'd0,
		ST_SYNTAX = 2'd1,
		ST_LONG   = 2'd2
	} status_t;

	typedef struct packed {
		event_t     ev;
		logic [7:0] ch;
		status_t    st;
		logic       last;
	} res_t;

	// up to two results produced by one byte
	typedef struct packed {
		logic [1:0] n;
		res_t       r0;
		res_t       r1;
	} res_pair_t;

endpackage

// ===== rtl/ilt_parser.sv =====
`timescale 1ns / 1ps

module ilt_parser (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               step,
	input  logic [7:0]         ch,
	input  logic               eoi,
	output ilt_pkg::res_pair_t res
);

	ilt_pkg::phase_t               phase_q, phase_d;
	logic [ilt_pkg::LEN_W-1:0]     len_q, len_d;
	ilt_pkg::status_t              sticky_q, sticky_d;

	logic blank;
	logic ok1, ok2;
	logic [1:0] n;
	ilt_pkg::res_t r0, r1;

	function automatic ilt_pkg::res_t mk(ilt_pkg::event_t ev, logic [7:0] c,
		ilt_pkg::status_t st);
		ilt_pkg::res_t r;
		r.ev   = ev;
		r.ch   = c;
		r.st   = st;
		r.last = 1'b0;
		return r;
	endfunction

	assign blank = (ch == ilt_pkg::CH_SPACE) || (ch == ilt_pkg::CH_TAB);
	// room for one / two more held characters
	assign ok1 = len_q < ilt_pkg::LEN_W'(ilt_pkg::MAX_LEN - 1);
	assign ok2 = len_q < ilt_pkg::LEN_W'(ilt_pkg::MAX_LEN - 2);

	always_comb begin
		phase_d  = phase_q;
		len_d    = len_q;
		sticky_d = sticky_q;
		n        = 2'd0;
		r0       = '0;
		r1       = '0;
		if (step) begin
			unique case (phase_q)
				ilt_pkg::PH_LINE, ilt_pkg::PH_VALUE_NL: begin
					if (eoi) begin
						if (phase_q == ilt_pkg::PH_VALUE_NL) begin
							r0 = mk(ilt_pkg::EV_PAIR_END, 8'h00, ilt_pkg::ST_OK);
							r1 = mk(ilt_pkg::EV_FINISHED, 8'h00, ilt_pkg::ST_OK);
							n  = 2'd2;
						end else begin
							r0 = mk(ilt_pkg::EV_FINISHED, 8'h00, ilt_pkg::ST_OK);
							n  = 2'd1;
						end
						phase_d = ilt_pkg::PH_DONE;
					end else if (phase_q == ilt_pkg::PH_VALUE_NL &&
						ch == ilt_pkg::CH_SPACE) begin
						// continuation: newline and space join the value
						if (!ok1) begin
							r0       = mk(ilt_pkg::EV_NONE, 8'h00, ilt_pkg::ST_LONG);
							n        = 2'd1;
							sticky_d = ilt_pkg::ST_LONG;
							phase_d  = ilt_pkg::PH_ERROR;
						end else if (!ok2) begin
							r0       = mk(ilt_pkg::EV_VAL_CHAR, ilt_pkg::CH_NEWLINE,
								ilt_pkg::ST_OK);
							r1       = mk(ilt_pkg::EV_NONE, 8'h00, ilt_pkg::ST_LONG);
							n        = 2'd2;
							len_d    = len_q + 1'b1;
							sticky_d = ilt_pkg::ST_LONG;
							phase_d  = ilt_pkg::PH_ERROR;
						end else begin
							r0      = mk(ilt_pkg::EV_VAL_CHAR, ilt_pkg::CH_NEWLINE,
								ilt_pkg::ST_OK);
							r1      = mk(ilt_pkg::EV_VAL_CHAR, ilt_pkg::CH_SPACE,
								ilt_pkg::ST_OK);
							n       = 2'd2;
							len_d   = len_q + ilt_pkg::LEN_W'(2);
							phase_d = ilt_pkg::PH_VALUE;
						end
					end else begin
						// line start; a pending pair is closed first
						if (phase_q == ilt_pkg::PH_VALUE_NL) begin
							r0 = mk(ilt_pkg::EV_PAIR_END, 8'h00, ilt_pkg::ST_OK);
							n  = 2'd1;
						end
						priority if (ch == ilt_pkg::CH_LBRACKET) begin
							phase_d = ilt_pkg::PH_SECT;
							len_d   = '0;
						end else if (ch == ilt_pkg::CH_NEWLINE ||
							ch == ilt_pkg::CH_SPACE) begin
							phase_d = ilt_pkg::PH_LINE;
						end else if (ch == ilt_pkg::CH_SEMI) begin
							phase_d = ilt_pkg::PH_COMMENT;
						end else begin
							phase_d = ilt_pkg::PH_KEY;
							len_d   = ilt_pkg::LEN_W'(1);
							if (phase_q == ilt_pkg::PH_VALUE_NL) begin
								r1 = mk(ilt_pkg::EV_KEY_CHAR, ch, ilt_pkg::ST_OK);
								n  = 2'd2;
							end else begin
								r0 = mk(ilt_pkg::EV_KEY_CHAR, ch, ilt_pkg::ST_OK);
								n  = 2'd1;
							end
						end
					end
				end
				ilt_pkg::PH_SECT: begin
					n = 2'd1;
					priority if (eoi || ch == ilt_pkg::CH_NEWLINE) begin
						r0       = mk(ilt_pkg::EV_NONE, 8'h00, ilt_pkg::ST_SYNTAX);
						sticky_d = ilt_pkg::ST_SYNTAX;
						phase_d  = ilt_pkg::PH_ERROR;
					end else if (ch == ilt_pkg::CH_RBRACKET) begin
						r0      = mk(ilt_pkg::EV_SECT_END, 8'h00, ilt_pkg::ST_OK);
						phase_d = ilt_pkg::PH_SECT_END;
					end else if (ok1) begin
						r0    = mk(ilt_pkg::EV_SECT_CHAR, ch, ilt_pkg::ST_OK);
						len_d = len_q + 1'b1;
					end else begin
						r0       = mk(ilt_pkg::EV_NONE, 8'h00, ilt_pkg::ST_LONG);
						sticky_d = ilt_pkg::ST_LONG;
						phase_d  = ilt_pkg::PH_ERROR;
					end
				end
				ilt_pkg::PH_SECT_END, ilt_pkg::PH_COMMENT: begin
					priority if (eoi) begin
						r0      = mk(ilt_pkg::EV_FINISHED, 8'h00, ilt_pkg::ST_OK);
						n       = 2'd1;
						phase_d = ilt_pkg::PH_DONE;
					end else if (ch == ilt_pkg::CH_NEWLINE) begin
						phase_d = ilt_pkg::PH_LINE;
					end else if (phase_q == ilt_pkg::PH_SECT_END && !blank) begin
						r0       = mk(ilt_pkg::EV_NONE, 8'h00, ilt_pkg::ST_SYNTAX);
						n        = 2'd1;
						sticky_d = ilt_pkg::ST_SYNTAX;
						phase_d  = ilt_pkg::PH_ERROR;
					end else begin
						phase_d = phase_q;
					end
				end
				ilt_pkg::PH_KEY, ilt_pkg::PH_KEY_GAP: begin
					priority if (eoi || (phase_q == ilt_pkg::PH_KEY &&
						ch == ilt_pkg::CH_NEWLINE)) begin
						r0       = mk(ilt_pkg::EV_NONE, 8'h00, ilt_pkg::ST_SYNTAX);
						n        = 2'd1;
						sticky_d = ilt_pkg::ST_SYNTAX;
						phase_d  = ilt_pkg::PH_ERROR;
					end else if (ch == ilt_pkg::CH_EQUALS) begin
						// the '=' counts as one held character
						n = 2'd1;
						if (ok1) begin
							r0      = mk(ilt_pkg::EV_KEY_END, 8'h00, ilt_pkg::ST_OK);
							len_d   = len_q + 1'b1;
							phase_d = ilt_pkg::PH_VALUE;
						end else begin
							r0       = mk(ilt_pkg::EV_NONE, 8'h00, ilt_pkg::ST_LONG);
							sticky_d = ilt_pkg::ST_LONG;
							phase_d  = ilt_pkg::PH_ERROR;
						end
					end else if (blank) begin
						phase_d = ilt_pkg::PH_KEY_GAP;
					end else if (phase_q == ilt_pkg::PH_KEY_GAP) begin
						r0       = mk(ilt_pkg::EV_NONE, 8'h00, ilt_pkg::ST_SYNTAX);
						n        = 2'd1;
						sticky_d = ilt_pkg::ST_SYNTAX;
						phase_d  = ilt_pkg::PH_ERROR;
					end else if (ok1) begin
						r0    = mk(ilt_pkg::EV_KEY_CHAR, ch, ilt_pkg::ST_OK);
						n     = 2'd1;
						len_d = len_q + 1'b1;
					end else begin
						r0       = mk(ilt_pkg::EV_NONE, 8'h00, ilt_pkg::ST_LONG);
						n        = 2'd1;
						sticky_d = ilt_pkg::ST_LONG;
						phase_d  = ilt_pkg::PH_ERROR;
					end
				end
				ilt_pkg::PH_VALUE: begin
					priority if (eoi) begin
						r0      = mk(ilt_pkg::EV_PAIR_END, 8'h00, ilt_pkg::ST_OK);
						r1      = mk(ilt_pkg::EV_FINISHED, 8'h00, ilt_pkg::ST_OK);
						n       = 2'd2;
						phase_d = ilt_pkg::PH_DONE;
					end else if (ch == ilt_pkg::CH_NEWLINE) begin
						phase_d = ilt_pkg::PH_VALUE_NL;
					end else if (ok1) begin
						r0    = mk(ilt_pkg::EV_VAL_CHAR, ch, ilt_pkg::ST_OK);
						n     = 2'd1;
						len_d = len_q + 1'b1;
					end else begin
						r0       = mk(ilt_pkg::EV_NONE, 8'h00, ilt_pkg::ST_LONG);
						n        = 2'd1;
						sticky_d = ilt_pkg::ST_LONG;
						phase_d  = ilt_pkg::PH_ERROR;
					end
				end
				ilt_pkg::PH_DONE: begin
					phase_d = ilt_pkg::PH_DONE;
				end
				default: begin
					// error is sticky: report the stored status on every byte
					r0      = mk(ilt_pkg::EV_NONE, 8'h00, sticky_q);
					n       = 2'd1;
					phase_d = ilt_pkg::PH_ERROR;
				end
			endcase
		end
		r0.last = (n == 2'd1);
		r1.last = (n == 2'd2);
	end

	assign res.n  = n;
	assign res.r0 = r0;
	assign res.r1 = r1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= ilt_pkg::PH_LINE;
			len_q    <= '0;
			sticky_q <= ilt_pkg::ST_OK;
		end else begin
			phase_q  <= phase_d;
			len_q    <= len_d;
			sticky_q <= sticky_d;
		end
	end

	a_error_has_status: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == ilt_pkg::PH_ERROR |-> sticky_q != ilt_pkg::ST_OK)
		else $error("error phase with ok status");

	a_len_bound: assert property (@(posedge clk) disable iff (!arst_n)
		len_q < ilt_pkg::LEN_W'(ilt_pkg::MAX_LEN))
		else $error("length count past limit");

	a_done_silent: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == ilt_pkg::PH_DONE |-> res.n == 2'd0)
		else $error("results after finish");

endmodule

// ===== rtl/ilt_result_fifo.sv =====
`timescale 1ns / 1ps

module ilt_result_fifo (
	input  logic               clk,
	input  logic               arst_n,
	input  ilt_pkg::res_pair_t push,
	output logic               room,
	output logic               res_valid,
	input  logic               res_stall,
	output logic [2:0]         event_res,
	output logic [7:0]         char_out,
	output logic [1:0]         status,
	output logic               last
);

	ilt_pkg::res_t                 ent_q [ilt_pkg::FIFO_DEPTH];
	logic [ilt_pkg::PTR_W-1:0]     wr_q, rd_q;
	logic [ilt_pkg::CNT_W-1:0]     cnt_q;
	logic                          pop;
	ilt_pkg::res_t                 head;

	assign head      = ent_q[rd_q];
	assign res_valid = (cnt_q != '0);
	assign pop       = res_valid && !res_stall;
	// the parser may emit two results per byte
	assign room      = cnt_q <= ilt_pkg::CNT_W'(ilt_pkg::FIFO_DEPTH - 2);

	assign event_res = head.ev;
	assign char_out  = head.ch;
	assign status    = head.st;
	assign last      = head.last;

	always_ff @(posedge clk) begin
		if (push.n != 2'd0) begin
			ent_q[wr_q] <= push.r0;
		end
		if (push.n == 2'd2) begin
			ent_q[wr_q + ilt_pkg::PTR_W'(1)] <= push.r1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			wr_q  <= wr_q + ilt_pkg::PTR_W'(push.n);
			rd_q  <= rd_q + ilt_pkg::PTR_W'(pop);
			cnt_q <= cnt_q + ilt_pkg::CNT_W'(push.n) - ilt_pkg::CNT_W'(pop);
		end
	end

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= ilt_pkg::CNT_W'(ilt_pkg::FIFO_DEPTH))
		else $error("result queue overfilled");

	a_push_needs_room: assert property (@(posedge clk) disable iff (!arst_n)
		push.n != 2'd0 |-> room)
		else $error("push without room");

	a_pair_last: assert property (@(posedge clk) disable iff (!arst_n)
		push.n == 2'd2 |-> push.r1.last && !push.r0.last)
		else $error("last flag misplaced on a result pair");

endmodule

// ===== rtl/ini_line_tokenizer_unit.sv =====
`timescale 1ns / 1ps

// INI line tokenizer.
// Input channel: one beat per file byte (byte_in), or an end-of-file mark
// (end_of_input = 1, byte_in ignored). item_valid/item_stall handshake.
// Result channel: one beat per event (event_res, char_out, status, last);
// last marks the final result caused by one input beat. A byte may cause
// no result, one, or two (pair end plus finished, pair end plus key char,
// two value chars on a line continuation, or a value char plus an error).
// A byte passes the input register, then the parser, into a four-entry
// result queue.
// Throughput: one byte per cycle while each byte yields at most one
// result and the receiver does not stall; a byte with two results leaves
// them one after the other through the single result port behind the queue.
// Reset puts the parser at line start with a zero length count and ok
// status, and empties the queue. When the receiver stalls, the queue
// fills, then the input register holds and item_stall rises.
// After an error every byte gives one error beat; after finished, none.
module ini_line_tokenizer_unit (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       item_valid,
	output logic       item_stall,
	input  logic [7:0] byte_in,
	input  logic       end_of_input,
	output logic       res_valid,
	input  logic       res_stall,
	output logic [2:0] event_res,
	output logic [7:0] char_out,
	output logic [1:0] status,
	output logic       last
);

	logic               valid_s1;
	logic [7:0]         byte_s1;
	logic               eoi_s1;
	logic               room;
	logic               step;
	logic               accept;
	ilt_pkg::res_pair_t pair;

	assign step       = valid_s1 && room;
	assign item_stall = valid_s1 && !room;
	assign accept     = item_valid && !item_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept || (valid_s1 && !step);
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			byte_s1 <= byte_in;
			eoi_s1  <= end_of_input;
		end
	end

	ilt_parser u_parser (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step),
		.ch     (byte_s1),
		.eoi    (eoi_s1),
		.res    (pair)
	);

	ilt_result_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (pair),
		.room      (room),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.event_res (event_res),
		.char_out  (char_out),
		.status    (status),
		.last      (last)
	);

endmodule

// ===== dv/tb_ini_line_tokenizer_unit.sv =====
`timescale 1ns / 1ps

module tb_ini_line_tokenizer_unit;
	import ilt_pkg::*;

	localparam int HALF_PERIOD    = 10;
	localparam int RESET_CYCLES   = 11;
	localparam int BODY_ITEMS     = 1850;
	localparam int CALM_AFTER     = 1700;
	localparam int MID_DRAIN_AT   = 900;
	localparam int WATCHDOG_LIMIT = 1000;
	localparam int SETTLE_CYCLES  = 12;
	localparam int MAX_REPORTS    = 100;

	// how the byte stream is closed; the parser sticks afterwards
	typedef enum int {
		TC_EOF_LINE,
		TC_EOF_COMMENT,
		TC_EOF_SECT_END,
		TC_EOF_VALUE,
		TC_EOF_VALUE_NL,
		TC_EOF_SECT,
		TC_EOF_KEY,
		TC_EOF_GAP,
		TC_NL_SECT,
		TC_NL_KEY,
		TC_JUNK_SECT_END,
		TC_JUNK_GAP,
		TC_LONG_SECT,
		TC_LONG_KEY,
		TC_LONG_VALUE,
		TC_LONG_CONT
	} tail_case_t;

	class token_scoreboard;
		res_t             due_q[$];
		phase_t           phase;
		logic [LEN_W-1:0] held;
		status_t          stuck;
		int               errors;
		int               seen;

		function new();
			phase  = PH_LINE;
			held   = '0;
			stuck  = ST_OK;
			errors = 0;
			seen   = 0;
		endfunction

		function int pending();
			return due_q.size();
		endfunction

		function void emit(event_t ev, logic [7:0] ch, status_t st);
			res_t r;
			r.ev   = ev;
			r.ch   = ch;
			r.st   = st;
			r.last = 1'b0;
			due_q.push_back(r);
		endfunction

		function void trip(status_t st);
			stuck = st;
			phase = PH_ERROR;
			emit(EV_NONE, 8'h00, st);
		endfunction

		// one more held character; errors out at the length limit
		function bit count_one();
			if (int'(held) + 1 >= MAX_LEN) begin
				trip(ST_LONG);
				return 1'b0;
			end
			held = held + 1'b1;
			return 1'b1;
		endfunction

		function void open_line(logic [7:0] c);
			if (c == CH_LBRACKET) begin
				phase = PH_SECT;
				held  = '0;
			end else if (c == CH_NEWLINE || c == CH_SPACE) begin
				phase = PH_LINE;
			end else if (c == CH_SEMI) begin
				phase = PH_COMMENT;
			end else begin
				phase = PH_KEY;
				held  = LEN_W'(1);
				emit(EV_KEY_CHAR, c, ST_OK);
			end
		endfunction

		function void close_key();
			if (count_one()) begin
				emit(EV_KEY_END, 8'h00, ST_OK);
				phase = PH_VALUE;
			end
		endfunction

		function void value_byte(logic [7:0] c);
			if (count_one())
				emit(EV_VAL_CHAR, c, ST_OK);
		endfunction

		function void wrap_up(bit with_pair);
			if (with_pair)
				emit(EV_PAIR_END, 8'h00, ST_OK);
			emit(EV_FINISHED, 8'h00, ST_OK);
			phase = PH_DONE;
		endfunction

		function void note_byte(logic [7:0] c, logic eof);
			int base;
			bit blank;
			base  = due_q.size();
			blank = (c == CH_SPACE || c == CH_TAB);
			case (phase)
				PH_LINE: begin
					if (eof) wrap_up(1'b0);
					else open_line(c);
				end
				PH_SECT: begin
					if (eof || c == CH_NEWLINE) begin
						trip(ST_SYNTAX);
					end else if (c == CH_RBRACKET) begin
						emit(EV_SECT_END, 8'h00, ST_OK);
						phase = PH_SECT_END;
					end else if (count_one()) begin
						emit(EV_SECT_CHAR, c, ST_OK);
					end
				end
				PH_SECT_END: begin
					if (eof) wrap_up(1'b0);
					else if (c == CH_NEWLINE) phase = PH_LINE;
					else if (!blank) trip(ST_SYNTAX);
				end
				PH_COMMENT: begin
					if (eof) wrap_up(1'b0);
					else if (c == CH_NEWLINE) phase = PH_LINE;
				end
				PH_KEY: begin
					if (eof || c == CH_NEWLINE) trip(ST_SYNTAX);
					else if (blank) phase = PH_KEY_GAP;
					else if (c == CH_EQUALS) close_key();
					else if (count_one()) emit(EV_KEY_CHAR, c, ST_OK);
				end
				PH_KEY_GAP: begin
					if (eof) trip(ST_SYNTAX);
					else if (c == CH_EQUALS) close_key();
					else if (!blank) trip(ST_SYNTAX);
				end
				PH_VALUE: begin
					if (eof) wrap_up(1'b1);
					else if (c == CH_NEWLINE) phase = PH_VALUE_NL;
					else value_byte(c);
				end
				PH_VALUE_NL: begin
					if (eof) begin
						wrap_up(1'b1);
					end else if (c == CH_SPACE) begin
						// continuation: line break and the space both join the value
						phase = PH_VALUE;
						value_byte(CH_NEWLINE);
						if (phase == PH_VALUE)
							value_byte(CH_SPACE);
					end else begin
						emit(EV_PAIR_END, 8'h00, ST_OK);
						open_line(c);
					end
				end
				PH_DONE: ;
				default: begin
					phase = PH_ERROR;
					emit(EV_NONE, 8'h00, stuck);
				end
			endcase
			if (due_q.size() > base)
				due_q[due_q.size() - 1].last = 1'b1;
		endfunction

		task report(string msg);
			if (errors < MAX_REPORTS)
				$display("MISMATCH: %s", msg);
			errors++;
		endtask

		task check_result(logic [2:0] ev, logic [7:0] ch, logic [1:0] st, logic lst);
			res_t want;
			seen++;
			if (due_q.size() == 0) begin
				report($sformatf("beat %0d ev=%0d ch=%02h st=%0d last=%0b with nothing due",
					seen, ev, ch, st, lst));
			end else begin
				want = due_q.pop_front();
				if (ev !== want.ev || ch !== want.ch || st !== want.st ||
					lst !== want.last)
					report($sformatf({"beat %0d got ev=%0d ch=%02h st=%0d last=%0b, ",
						"want ev=%0d ch=%02h st=%0d last=%0b"},
						seen, ev, ch, st, lst, want.ev, want.ch, want.st, want.last));
			end
		endtask
	endclass

	logic       clk          = 1'b0;
	logic       arst_n       = 1'b0;
	logic       item_valid   = 1'b0;
	logic       item_stall;
	logic [7:0] byte_in      = 8'h00;
	logic       end_of_input = 1'b0;
	logic       res_valid;
	logic       res_stall    = 1'b0;
	logic [2:0] event_res;
	logic [7:0] char_out;
	logic [1:0] status;
	logic       last;

	token_scoreboard sb = new();

	int         sent = 0;
	bit         calm = 1'b0;
	int         quiet_cycles = 0;
	bit [255:0] name_ban;
	bit [255:0] key_ban;
	bit [255:0] lead_ban;
	bit [255:0] text_ban;

	ini_line_tokenizer_unit DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.byte_in      (byte_in),
		.end_of_input (end_of_input),
		.res_valid    (res_valid),
		.res_stall    (res_stall),
		.event_res    (event_res),
		.char_out     (char_out),
		.status       (status),
		.last         (last)
	);

	always #HALF_PERIOD clk = ~clk;

	// every third window of 150 beats runs without idling
	function automatic bit idle_allowed();
		return !calm && ((sent / 150) % 3 != 2);
	endfunction

	function automatic logic [7:0] pick_byte(bit [255:0] ban);
		logic [7:0] b;
		do b = 8'($urandom_range(0, 255)); while (ban[b]);
		return b;
	endfunction

	task automatic send(input logic [7:0] b, input logic eof);
		if (idle_allowed() && $urandom_range(0, 7) == 0) begin
			item_valid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
		item_valid   <= 1'b1;
		byte_in      <= b;
		end_of_input <= eof;
		do @(posedge clk); while (item_stall);
		sb.note_byte(b, eof);
		sent++;
	endtask

	task automatic send_str(input string s);
		for (int i = 0; i < s.len(); i++)
			send(s[i], 1'b0);
	endtask

	task automatic send_rand(input bit [255:0] ban, input int n);
		repeat (n) send(pick_byte(ban), 1'b0);
	endtask

	task automatic send_blanks(input int n);
		repeat (n) send($urandom_range(0, 1) ? CH_SPACE : CH_TAB, 1'b0);
	endtask

	task automatic send_key(input int n);
		send(pick_byte(lead_ban), 1'b0);
		send_rand(key_ban, n - 1);
	endtask

	task automatic send_eof();
		send(8'($urandom_range(0, 255)), 1'b1);
	endtask

	// sender holds off until every expected result has left
	task automatic drain_results();
		item_valid <= 1'b0;
		do @(posedge clk); while (sb.pending() != 0);
	endtask

	task automatic gen_line();
		int pick;
		pick = $urandom_range(0, 9);
		// after a value a leading space turns the line into a continuation
		if ($urandom_range(0, 3) == 0)
			repeat ($urandom_range(1, 2)) send(CH_SPACE, 1'b0);
		if (pick == 0) begin
			send(CH_NEWLINE, 1'b0);
		end else if (pick == 1) begin
			send(CH_SEMI, 1'b0);
			send_rand(text_ban, $urandom_range(0, 15));
			send(CH_NEWLINE, 1'b0);
		end else if (pick <= 3) begin
			send(CH_LBRACKET, 1'b0);
			send_rand(name_ban, $urandom_range(0, 10));
			send(CH_RBRACKET, 1'b0);
			send_blanks($urandom_range(0, 2));
			send(CH_NEWLINE, 1'b0);
		end else begin
			send_key($urandom_range(1, 9));
			send_blanks($urandom_range(0, 2));
			send(CH_EQUALS, 1'b0);
			send_rand(text_ban, $urandom_range(0, 15));
			repeat ($urandom_range(0, 2)) begin
				send(CH_NEWLINE, 1'b0);
				send(CH_SPACE, 1'b0);
				send_rand(text_ban, $urandom_range(0, 10));
			end
			send(CH_NEWLINE, 1'b0);
		end
	endtask

	task automatic close_stream(input tail_case_t tc);
		case (tc)
			TC_EOF_LINE: send_eof();
			TC_EOF_COMMENT: begin
				send(CH_SEMI, 1'b0);
				send_rand(text_ban, $urandom_range(0, 5));
				send_eof();
			end
			TC_EOF_SECT_END: begin
				send_str("[s]");
				send_blanks($urandom_range(0, 2));
				send_eof();
			end
			TC_EOF_VALUE: begin
				send_key($urandom_range(1, 4));
				send(CH_EQUALS, 1'b0);
				send_rand(text_ban, $urandom_range(0, 5));
				send_eof();
			end
			TC_EOF_VALUE_NL: begin
				send_str("k=v\n");
				send_eof();
			end
			TC_EOF_SECT: begin
				send(CH_LBRACKET, 1'b0);
				send_rand(name_ban, $urandom_range(0, 4));
				send_eof();
			end
			TC_EOF_KEY: begin
				send_key($urandom_range(1, 4));
				send_eof();
			end
			TC_EOF_GAP: begin
				send_key($urandom_range(1, 4));
				send_blanks($urandom_range(1, 3));
				send_eof();
			end
			TC_NL_SECT: send_str("[ab\n");
			TC_NL_KEY: send_str("ab\n");
			TC_JUNK_SECT_END: begin
				send_str("[s] ");
				send(pick_byte(key_ban), 1'b0);
			end
			TC_JUNK_GAP: begin
				send_str("ab ");
				send(pick_byte(key_ban), 1'b0);
			end
			TC_LONG_SECT: begin
				send(CH_LBRACKET, 1'b0);
				send_rand(name_ban, MAX_LEN);
			end
			TC_LONG_KEY: begin
				send_key(MAX_LEN - 1);
				send(CH_EQUALS, 1'b0);
			end
			TC_LONG_VALUE: begin
				send_str("k=");
				send_rand(text_ban, MAX_LEN);
			end
			TC_LONG_CONT: begin
				send_str("k=");
				repeat (MAX_LEN / 2) send_str("\n ");
			end
			default: send_eof();
		endcase
	endtask

	always @(posedge clk) begin
		if (arst_n && res_valid && !res_stall)
			sb.check_result(event_res, char_out, status, last);
	end

	always @(posedge clk) begin
		if (!arst_n || (item_valid && !item_stall) || (res_valid && !res_stall)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("ini_line_tokenizer_unit regression: fail");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		repeat (RESET_CYCLES + 1) @(posedge clk);
		forever begin
			@(posedge clk);
			if (idle_allowed() && $urandom_range(0, 5) == 0) begin
				res_stall <= 1'b1;
				repeat ($urandom_range(1, 5)) @(posedge clk);
			end
			res_stall <= 1'b0;
		end
	end

	initial begin
		tail_case_t tc;
		bit         mid_drained;
		mid_drained = 1'b0;
		name_ban = '0;
		name_ban[CH_RBRACKET] = 1'b1;
		name_ban[CH_NEWLINE]  = 1'b1;
		key_ban = '0;
		key_ban[CH_NEWLINE] = 1'b1;
		key_ban[CH_SPACE]   = 1'b1;
		key_ban[CH_TAB]     = 1'b1;
		key_ban[CH_EQUALS]  = 1'b1;
		lead_ban = '0;
		lead_ban[CH_LBRACKET] = 1'b1;
		lead_ban[CH_SPACE]    = 1'b1;
		lead_ban[CH_NEWLINE]  = 1'b1;
		lead_ban[CH_SEMI]     = 1'b1;
		text_ban = '0;
		text_ban[CH_NEWLINE] = 1'b1;

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// section with trailing blanks, comment, key gap, byte extremes,
		// continuation, tab-led key with empty value, empty section
		send_str("[a]\t \n;x\n k \t=");
		send(8'hFF, 1'b0);
		send_str("\n ");
		send(8'h00, 1'b0);
		send_str("\n\tq=\n[]\n");
		drain_results();

		while (sent < BODY_ITEMS) begin
			if (sent >= CALM_AFTER)
				calm = 1'b1;
			if (!mid_drained && sent >= MID_DRAIN_AT) begin
				drain_results();
				mid_drained = 1'b1;
			end
			gen_line();
		end
		calm = 1'b1;

		send(CH_NEWLINE, 1'b0);
		tc = tail_case_t'($urandom_range(0, TC_LONG_CONT));
		close_stream(tc);
		// parser is stuck now: done gives nothing, an error repeats its status
		repeat ($urandom_range(8, 20))
			send(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);

		drain_results();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (sb.errors == 0)
			$display("ini_line_tokenizer_unit regression: pass");
		else
			$display("ini_line_tokenizer_unit regression: fail");
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/ilt_pkg.sv
rtl/ilt_parser.sv
rtl/ilt_result_fifo.sv
rtl/ini_line_tokenizer_unit.sv
dv/tb_ini_line_tokenizer_unit.sv
